[rtl/byte_limited_packet_queue_defines.svh]
// assertion macros for the byte limited packet queue
`ifndef BYTE_LIMITED_PACKET_QUEUE_DEFINES_SVH
`define BYTE_LIMITED_PACKET_QUEUE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BLPQ_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("blpq same-cycle check failed");

// next-cycle implication, checked out of reset
`define BLPQ_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("blpq next-cycle check failed");

`endif

[rtl/blpq_pkg.sv]
// shared types, widths and codes for the byte limited packet queue
package blpq_pkg;

  localparam int unsigned QueueDepthDefault = 64;

  localparam int unsigned TagW       = 16;
  localparam int unsigned BytesW     = 14;
  localparam int unsigned KindW      = 2;
  localparam int unsigned PrioW      = 8;
  localparam int unsigned ModeW      = 2;
  localparam int unsigned LimitW     = 20;
  localparam int unsigned HeldBytesW = 21;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned RegIdxW    = 1;
  localparam int unsigned InTdataW   = 48;

  // drop modes
  localparam logic [ModeW-1:0] MODE_NEWEST_NORMAL = 2'd0;
  localparam logic [ModeW-1:0] MODE_EVICT_ARRIVAL = 2'd1;
  localparam logic [ModeW-1:0] MODE_HIGHEST_PRIO  = 2'd2;

  // result status codes
  localparam logic [StatusW-1:0] STATUS_ACCEPTED = 2'd0;
  localparam logic [StatusW-1:0] STATUS_EVICTED  = 2'd1;
  localparam logic [StatusW-1:0] STATUS_DEQUEUED = 2'd2;
  localparam logic [StatusW-1:0] STATUS_EMPTY    = 2'd3;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  localparam logic [RegIdxW-1:0] REG_DROP_MODE  = 1'b0;
  localparam logic [RegIdxW-1:0] REG_BYTE_LIMIT = 1'b1;

  localparam logic [KindW-1:0] KIND_NORMAL = 2'd0;

  localparam logic [ModeW-1:0]  DropModeReset  = MODE_NEWEST_NORMAL;
  localparam logic [LimitW-1:0] ByteLimitReset = 20'hFFFFF;

  typedef struct packed {
    logic [PrioW-1:0]  prio;
    logic [KindW-1:0]  kind;
    logic [BytesW-1:0] bytes;
    logic [TagW-1:0]   tag;
  } desc_t;

  localparam int unsigned DescW = $bits(desc_t);

  typedef struct packed {
    logic [StatusW-1:0]    status;
    desc_t                 desc;
    logic [HeldBytesW-1:0] held_bytes;
  } res_t;

endpackage

[rtl/blpq_ram.sv]
// generic single write, single read ram with registered read data
module blpq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/blpq_ctrl.sv]
// sequencer: victim and control search, store compaction and running totals
module blpq_ctrl #(
  parameter int unsigned QUEUE_DEPTH = blpq_pkg::QueueDepthDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 in_opcode_i,
  input  blpq_pkg::desc_t                      in_desc_i,
  input  logic [blpq_pkg::ModeW-1:0]           drop_mode_i,
  input  logic [blpq_pkg::LimitW-1:0]          byte_limit_i,
  output logic                                 ram_we_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]     ram_waddr_o,
  output logic [blpq_pkg::DescW-1:0]           ram_wdata_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]     ram_raddr_o,
  input  logic [blpq_pkg::DescW-1:0]           ram_rdata_i,
  output logic                                 res_valid_o,
  output blpq_pkg::res_t                       res_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]     res_count_o,
  input  logic                                 res_take_i
);

  localparam int unsigned AddrW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CntW    = $clog2(QUEUE_DEPTH + 2);
  localparam int unsigned OutCntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(QUEUE_DEPTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]                        state_q, state_d;
  logic [CntW-1:0]                   cnt_q, cnt_d;
  logic [blpq_pkg::HeldBytesW-1:0]   bytes_q, bytes_d;
  logic [CntW-1:0]                   left_q, left_d;
  logic                              dv_q, dv_d;
  logic                              enq_q, enq_d;
  logic                              up_q, up_d;
  logic [CntW-1:0]                   cur_cnt_q, cur_cnt_d;
  logic [blpq_pkg::HeldBytesW-1:0]   sum_q, sum_d;
  logic [AddrW-1:0]                  ptr_q, ptr_d;
  logic [AddrW-1:0]                  da_q, da_d;
  logic [AddrW-1:0]                  idx_q, idx_d;
  blpq_pkg::desc_t                   vic_q, vic_d;
  logic [blpq_pkg::StatusW-1:0]      status_q, status_d;

  blpq_pkg::desc_t                   rd;
  logic [blpq_pkg::HeldBytesW-1:0]   sum_new;
  logic                              hit;
  logic                              stop_on_hit;
  logic                              removed;
  logic [CntW-1:0]                   fin_cnt;
  logic [blpq_pkg::HeldBytesW-1:0]   fin_bytes;

  assign rd      = blpq_pkg::desc_t'(ram_rdata_i);
  assign sum_new = bytes_q + blpq_pkg::HeldBytesW'(in_desc_i.bytes);

  // shared compare unit: one stored entry per cycle against the current pick
  always_comb begin
    if (enq_q) begin
      if (drop_mode_i == blpq_pkg::MODE_HIGHEST_PRIO) begin
        hit = rd.prio > vic_q.prio;
      end else begin
        hit = rd.kind == blpq_pkg::KIND_NORMAL;
      end
    end else begin
      hit = (drop_mode_i == blpq_pkg::MODE_EVICT_ARRIVAL) ||
            (rd.kind != blpq_pkg::KIND_NORMAL);
    end
  end

  // the priority search must see every entry, the others stop at the first hit
  assign stop_on_hit = !(enq_q && (drop_mode_i == blpq_pkg::MODE_HIGHEST_PRIO));

  assign removed   = (status_q == blpq_pkg::STATUS_EVICTED) ||
                     (status_q == blpq_pkg::STATUS_DEQUEUED);
  assign fin_cnt   = removed ? CntW'(cur_cnt_q - 1'b1) : cur_cnt_q;
  assign fin_bytes = removed ? blpq_pkg::HeldBytesW'(sum_q -
                                 blpq_pkg::HeldBytesW'(vic_q.bytes)) : sum_q;

  always_comb begin
    logic [AddrW-1:0] idx_n;
    blpq_pkg::desc_t  vic_n;

    state_d   = state_q;
    cnt_d     = cnt_q;
    bytes_d   = bytes_q;
    left_d    = left_q;
    dv_d      = 1'b0;
    da_d      = ptr_q;
    enq_d     = enq_q;
    up_d      = up_q;
    cur_cnt_d = cur_cnt_q;
    sum_d     = sum_q;
    ptr_d     = ptr_q;
    idx_d     = idx_q;
    vic_d     = vic_q;
    status_d  = status_q;
    idx_n     = idx_q;
    vic_n     = vic_q;

    ram_we_o    = 1'b0;
    ram_waddr_o = AddrW'(da_q - 1'b1);
    ram_wdata_o = ram_rdata_i;
    ram_raddr_o = ptr_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          enq_d = in_opcode_i == blpq_pkg::OP_ENQUEUE;
          if (in_opcode_i == blpq_pkg::OP_ENQUEUE) begin
            // the arrival always lands at the tail first
            ram_we_o    = 1'b1;
            ram_waddr_o = cnt_q[AddrW-1:0];
            ram_wdata_o = in_desc_i;
            cur_cnt_d   = CntW'(cnt_q + 1'b1);
            sum_d       = sum_new;
            vic_d       = in_desc_i;
            idx_d       = cnt_q[AddrW-1:0];
            if ((sum_new > {1'b0, byte_limit_i}) || (cnt_q == DepthCnt)) begin
              status_d = blpq_pkg::STATUS_EVICTED;
              if ((cnt_q != '0) &&
                  ((drop_mode_i == blpq_pkg::MODE_HIGHEST_PRIO) ||
                   ((drop_mode_i == blpq_pkg::MODE_NEWEST_NORMAL) &&
                    (in_desc_i.kind != blpq_pkg::KIND_NORMAL)))) begin
                state_d = ST_SCAN;
                up_d    = 1'b0;
                ptr_d   = AddrW'(cnt_q - 1'b1);
                left_d  = cnt_q;
              end else begin
                // arrival is the victim, nothing behind it to compact
                state_d = ST_SHIFT;
                left_d  = '0;
              end
            end else begin
              status_d = blpq_pkg::STATUS_ACCEPTED;
              vic_d    = '0;
              state_d  = ST_DONE;
            end
          end else begin
            cur_cnt_d = cnt_q;
            sum_d     = bytes_q;
            vic_d     = '0;
            idx_d     = '0;
            if (cnt_q == '0) begin
              status_d = blpq_pkg::STATUS_EMPTY;
              state_d  = ST_DONE;
            end else begin
              status_d = blpq_pkg::STATUS_DEQUEUED;
              state_d  = ST_SCAN;
              up_d     = 1'b1;
              ptr_d    = '0;
              left_d   = (drop_mode_i == blpq_pkg::MODE_EVICT_ARRIVAL) ? CntW'(1) : cnt_q;
            end
          end
        end
      end

      ST_SCAN: begin
        if (left_q != '0) begin
          dv_d   = 1'b1;
          da_d   = ptr_q;
          ptr_d  = up_q ? AddrW'(ptr_q + 1'b1) : AddrW'(ptr_q - 1'b1);
          left_d = CntW'(left_q - 1'b1);
        end
        if (dv_q) begin
          // head is the fallback pick of a dequeue
          if (!enq_q && (da_q == '0)) begin
            idx_n = '0;
            vic_n = rd;
          end
          if (hit) begin
            idx_n = da_q;
            vic_n = rd;
          end
          idx_d = idx_n;
          vic_d = vic_n;
          if ((hit && stop_on_hit) || (left_q == '0)) begin
            state_d = ST_SHIFT;
            dv_d    = 1'b0;
            ptr_d   = AddrW'(idx_n + 1'b1);
            left_d  = CntW'(cur_cnt_q - CntW'(idx_n) - 1'b1);
          end
        end
      end

      ST_SHIFT: begin
        // read entry i+1, write it to i in the cycle after
        if (left_q != '0) begin
          dv_d   = 1'b1;
          da_d   = ptr_q;
          ptr_d  = AddrW'(ptr_q + 1'b1);
          left_d = CntW'(left_q - 1'b1);
        end
        if (dv_q) begin
          ram_we_o = 1'b1;
        end
        if ((left_q == '0) && !dv_q) begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (res_take_i) begin
          cnt_d   = fin_cnt;
          bytes_d = fin_bytes;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      bytes_q <= '0;
      left_q  <= '0;
      dv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      bytes_q <= bytes_d;
      left_q  <= left_d;
      dv_q    <= dv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    enq_q     <= enq_d;
    up_q      <= up_d;
    cur_cnt_q <= cur_cnt_d;
    sum_q     <= sum_d;
    ptr_q     <= ptr_d;
    da_q      <= da_d;
    idx_q     <= idx_d;
    vic_q     <= vic_d;
    status_q  <= status_d;
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign res_valid_o = state_q == ST_DONE;
  assign res_o       = '{status: status_q, desc: vic_q, held_bytes: fin_bytes};
  assign res_count_o = OutCntW'(fin_cnt);

endmodule

[rtl/byte_limited_packet_queue.sv]
// top level of the byte limited packet queue
// Packet descriptor queue with a byte budget. Each input word is an enqueue or a
// dequeue and yields exactly one result word. An enqueue that leaves the queue
// within its byte limit and depth goes straight to its result. Every dequeue of a
// non-empty queue, and an evicting enqueue in priority mode or in newest-normal
// mode with a non-normal arrival, runs a search over the stored descriptors
// (one entry per cycle) followed by compaction of the entries behind the removed
// one (one entry per cycle), both through the single read port of the descriptor
// ram. Input ready is high only between items; a finished result waits in the
// output register while the next item is taken. The user must write drop_mode
// and byte_limit only while idle; the block itself does not enforce this.
`include "byte_limited_packet_queue_defines.svh"

module byte_limited_packet_queue #(
  parameter int unsigned QUEUE_DEPTH = blpq_pkg::QueueDepthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // opcode, pkt_tag, pkt_bytes, pkt_kind, pkt_priority, zero fill
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [blpq_pkg::InTdataW-1:0]      s_axis_tdata_i,
  // status, out_tag, out_bytes, out_kind, out_priority, held_bytes, held_count, zero fill
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [((blpq_pkg::StatusW + blpq_pkg::DescW + blpq_pkg::HeldBytesW +
                  $clog2(QUEUE_DEPTH+1) + 7) / 8) * 8 - 1:0] m_axis_tdata_o,
  input  logic                               cfg_we_i,
  input  logic [blpq_pkg::RegIdxW-1:0]       cfg_idx_i,
  input  logic [blpq_pkg::LimitW-1:0]        cfg_wdata_i
);

  localparam int unsigned AddrW     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned OutCntW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned OutFieldW = blpq_pkg::StatusW + blpq_pkg::DescW +
                                      blpq_pkg::HeldBytesW + OutCntW;
  localparam int unsigned OutTdataW = ((OutFieldW + 7) / 8) * 8;

  logic [blpq_pkg::ModeW-1:0]   drop_mode_q;
  logic [blpq_pkg::LimitW-1:0]  byte_limit_q;

  logic                         in_opcode;
  blpq_pkg::desc_t              in_desc;

  logic                         ram_we;
  logic [AddrW-1:0]             ram_waddr;
  logic [blpq_pkg::DescW-1:0]   ram_wdata;
  logic [AddrW-1:0]             ram_raddr;
  logic [blpq_pkg::DescW-1:0]   ram_rdata;

  logic                         res_valid;
  blpq_pkg::res_t               res;
  logic [OutCntW-1:0]           res_count;
  logic                         out_free;

  logic                         out_valid_q;
  blpq_pkg::res_t               out_res_q;
  logic [OutCntW-1:0]           out_cnt_q;

  logic                         in_fire;
  logic                         out_empty;

  assign in_opcode     = s_axis_tdata_i[0];
  assign in_desc.tag   = s_axis_tdata_i[16:1];
  assign in_desc.bytes = s_axis_tdata_i[30:17];
  assign in_desc.kind  = s_axis_tdata_i[32:31];
  assign in_desc.prio  = s_axis_tdata_i[40:33];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_mode_q  <= blpq_pkg::DropModeReset;
      byte_limit_q <= blpq_pkg::ByteLimitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        blpq_pkg::REG_DROP_MODE:  drop_mode_q  <= cfg_wdata_i[blpq_pkg::ModeW-1:0];
        blpq_pkg::REG_BYTE_LIMIT: byte_limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  blpq_ram #(
    .Width (blpq_pkg::DescW),
    .Depth (QUEUE_DEPTH + 1)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  blpq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_opcode_i  (in_opcode),
    .in_desc_i    (in_desc),
    .drop_mode_i  (drop_mode_q),
    .byte_limit_i (byte_limit_q),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_count_o  (res_count),
    .res_take_i   (out_free)
  );

  // output word register
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res_valid) begin
      out_res_q <= res;
      out_cnt_q <= res_count;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutTdataW'({out_cnt_q, out_res_q.held_bytes,
                                       out_res_q.desc.prio, out_res_q.desc.kind,
                                       out_res_q.desc.bytes, out_res_q.desc.tag,
                                       out_res_q.status});

  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_empty = out_valid_q && (out_res_q.status == blpq_pkg::STATUS_EMPTY);

  `BLPQ_ASSERT_NEXT(a_busy_after_accept, in_fire, !s_axis_tready_o)
  `BLPQ_ASSERT_NEXT(a_result_held_until_taken, res_valid && !out_free, res_valid)
  `BLPQ_ASSERT_NOW(a_empty_means_zero_count, out_empty, out_cnt_q == '0)
  `BLPQ_ASSERT_NOW(a_count_within_depth, out_valid_q, out_cnt_q <= OutCntW'(QUEUE_DEPTH))

endmodule

[tb/testbench.sv]
// self-checking testbench for the byte limited packet queue
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned Depth      = blpq_pkg::QueueDepthDefault;
  localparam int unsigned CountW     = $clog2(Depth + 1);
  localparam int unsigned OutW       = ((blpq_pkg::StatusW + blpq_pkg::DescW +
                                         blpq_pkg::HeldBytesW + CountW + 7) / 8) * 8;
  localparam int unsigned DrainWait  = 2 * Depth + 12;
  localparam int unsigned NumPhases  = 8;
  // drop mode 3: arrival evicted, control words still leave first
  localparam logic [blpq_pkg::ModeW-1:0] MODE_ARRIVAL_CTRL_FIRST = 2'd3;

  typedef struct packed {
    logic [blpq_pkg::StatusW-1:0]    status;
    blpq_pkg::desc_t                 desc;
    logic [blpq_pkg::HeldBytesW-1:0] held_bytes;
    logic [CountW-1:0]               held_count;
  } reply_t;

  class queue_mirror;
    blpq_pkg::desc_t              held[$];
    int unsigned                  held_total;
    logic [blpq_pkg::ModeW-1:0]   mode;
    logic [blpq_pkg::LimitW-1:0]  limit;
    reply_t                       replies_due[$];
    int unsigned                  errors;
    int unsigned                  n_enq, n_evict, n_deq, n_empty;

    function new();
      mode       = blpq_pkg::DropModeReset;
      limit      = blpq_pkg::ByteLimitReset;
      held_total = 0;
      errors     = 0;
      n_enq      = 0;
      n_evict    = 0;
      n_deq      = 0;
      n_empty    = 0;
    endfunction

    // work out the reply to one accepted word and queue it
    function void take_request(logic op, blpq_pkg::desc_t d);
      reply_t          r;
      int              idx;
      blpq_pkg::desc_t gone;
      r = '0;
      if (op == blpq_pkg::OP_ENQUEUE) begin
        n_enq++;
        held.insert(held.size(), d);
        held_total += d.bytes;
        if (held_total <= limit && held.size() <= Depth) begin
          r.status = blpq_pkg::STATUS_ACCEPTED;
        end else begin
          idx = held.size() - 1;
          if (mode == blpq_pkg::MODE_NEWEST_NORMAL) begin
            for (int i = held.size() - 1; i >= 0; i--) begin
              if (held[i].kind == blpq_pkg::KIND_NORMAL) begin
                idx = i;
                break;
              end
            end
          end else if (mode == blpq_pkg::MODE_HIGHEST_PRIO) begin
            // strict compare scanning from the tail keeps ties nearest the tail
            for (int i = held.size() - 1; i >= 0; i--) begin
              if (held[i].prio > held[idx].prio) idx = i;
            end
          end
          gone = held[idx];
          held.delete(idx);
          held_total -= gone.bytes;
          r.status = blpq_pkg::STATUS_EVICTED;
          r.desc   = gone;
          n_evict++;
        end
      end else if (held.size() == 0) begin
        r.status = blpq_pkg::STATUS_EMPTY;
        n_empty++;
      end else begin
        idx = 0;
        if (mode != blpq_pkg::MODE_EVICT_ARRIVAL) begin
          for (int i = 0; i < held.size(); i++) begin
            if (held[i].kind != blpq_pkg::KIND_NORMAL) begin
              idx = i;
              break;
            end
          end
        end
        gone = held[idx];
        held.delete(idx);
        held_total -= gone.bytes;
        r.status = blpq_pkg::STATUS_DEQUEUED;
        r.desc   = gone;
        n_deq++;
      end
      r.held_bytes = blpq_pkg::HeldBytesW'(held_total);
      r.held_count = CountW'(held.size());
      replies_due.insert(replies_due.size(), r);
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        errors++;
      end
    endfunction

    function void match_reply(logic [OutW-1:0] t);
      reply_t want;
      if (replies_due.size() == 0) begin
        $error("result word with no expectation pending: %h", t);
        errors++;
        return;
      end
      want = replies_due[0];
      replies_due.delete(0);
      compare("status",       32'(want.status),     32'(t[1:0]));
      compare("out_tag",      32'(want.desc.tag),   32'(t[17:2]));
      compare("out_bytes",    32'(want.desc.bytes), 32'(t[31:18]));
      compare("out_kind",     32'(want.desc.kind),  32'(t[33:32]));
      compare("out_priority", 32'(want.desc.prio),  32'(t[41:34]));
      compare("held_bytes",   32'(want.held_bytes), 32'(t[62:42]));
      compare("held_count",   32'(want.held_count), 32'(t[63 +: CountW]));
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni        = 1'b0;
  logic                          s_tvalid      = 1'b0;
  logic                          s_tready;
  logic [blpq_pkg::InTdataW-1:0] s_tdata       = '0;
  logic                          m_tvalid;
  logic                          m_tready      = 1'b0;
  logic [OutW-1:0]               m_tdata;
  logic                          cfg_we        = 1'b0;
  logic [blpq_pkg::RegIdxW-1:0]  cfg_idx       = blpq_pkg::REG_DROP_MODE;
  logic [blpq_pkg::LimitW-1:0]   cfg_wdata     = '0;
  bit                            no_gaps       = 1'b0;
  int unsigned                   n_settings    = 0;
  queue_mirror                   mirror;

  byte_limited_packet_queue #(
    .QUEUE_DEPTH(Depth)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  // result side: check each word taken, stall at random unless no_gaps is set
  always @(posedge clk_i) begin
    if (m_tvalid && m_tready) mirror.match_reply(m_tdata);
    m_tready <= no_gaps || ($urandom_range(99) >= 16);
  end

  // valid stays high after a word; the next call either replaces it or drops it
  task automatic send_word(logic op, blpq_pkg::desc_t d);
    if (!no_gaps && $urandom_range(99) < 16) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 40);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, d.prio, d.kind, d.bytes, d.tag, op};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    mirror.take_request(op, d);
  endtask

  task automatic enq(logic [15:0] tag, logic [13:0] nbytes, logic [1:0] kind,
                     logic [7:0] prio);
    blpq_pkg::desc_t d;
    d.tag   = tag;
    d.bytes = nbytes;
    d.kind  = kind;
    d.prio  = prio;
    send_word(blpq_pkg::OP_ENQUEUE, d);
  endtask

  task automatic deq();
    blpq_pkg::desc_t d;
    d = blpq_pkg::desc_t'(40'({$urandom, $urandom}));
    send_word(blpq_pkg::OP_DEQUEUE, d);
  endtask

  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    while (mirror.replies_due.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic set_config(logic [blpq_pkg::ModeW-1:0] mode,
                            logic [blpq_pkg::LimitW-1:0] limit);
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_idx   <= blpq_pkg::REG_DROP_MODE;
    cfg_wdata <= blpq_pkg::LimitW'(mode);
    @(posedge clk_i);
    cfg_idx   <= blpq_pkg::REG_BYTE_LIMIT;
    cfg_wdata <= limit;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    mirror.mode  = mode;
    mirror.limit = limit;
    n_settings++;
  endtask

  function automatic blpq_pkg::desc_t random_desc(bit tie_prio);
    blpq_pkg::desc_t d;
    d.tag = 16'($urandom);
    case ($urandom_range(9))
      0:       d.bytes = '0;
      1:       d.bytes = 14'h3FFF;
      2:       d.bytes = 14'($urandom_range(63));
      default: d.bytes = 14'($urandom);
    endcase
    d.kind = ($urandom_range(1) == 0) ? blpq_pkg::KIND_NORMAL : 2'($urandom_range(1, 3));
    if (tie_prio) d.prio = 8'($urandom_range(3));
    else if ($urandom_range(9) == 0) d.prio = ($urandom_range(1) == 0) ? 8'h00 : 8'hFF;
    else d.prio = 8'($urandom);
    return d;
  endfunction

  logic [blpq_pkg::ModeW-1:0]  phase_mode [NumPhases] = '{
    blpq_pkg::MODE_NEWEST_NORMAL, blpq_pkg::MODE_HIGHEST_PRIO,
    blpq_pkg::MODE_EVICT_ARRIVAL, MODE_ARRIVAL_CTRL_FIRST,
    blpq_pkg::MODE_HIGHEST_PRIO, blpq_pkg::MODE_NEWEST_NORMAL,
    blpq_pkg::MODE_EVICT_ARRIVAL, blpq_pkg::MODE_NEWEST_NORMAL};
  logic [blpq_pkg::LimitW-1:0] phase_limit[NumPhases] = '{
    20'hFFFFF, 20'd200000, 20'd0, 20'd50000, 20'hFFFFF, 20'd30000, 20'd0, 20'd1};
  int unsigned       phase_enq  [NumPhases] = '{80, 70, 60, 65, 80, 60, 55, 40};
  int unsigned       phase_len  [NumPhases] = '{160, 130, 100, 120, 160, 120, 120, 80};
  bit                phase_ties [NumPhases] = '{0, 1, 0, 0, 1, 0, 0, 1};

  initial begin
    logic [blpq_pkg::LimitW-1:0] limit;
    mirror = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings: empty queue, field extremes, control words jump the queue
    deq();
    enq(16'h0000, 14'h0000, blpq_pkg::KIND_NORMAL, 8'h00);
    enq(16'hFFFF, 14'h3FFF, 2'd3, 8'hFF);
    enq(16'h1234, 14'd100, 2'd1, 8'd7);
    enq(16'h5678, 14'd200, 2'd2, 8'd9);
    deq();
    deq();
    deq();
    deq();
    deq();

    // tight budget, newest normal word is evicted
    set_config(blpq_pkg::MODE_NEWEST_NORMAL, 20'd20000);
    enq(16'hA001, 14'd10000, blpq_pkg::KIND_NORMAL, 8'd1);
    enq(16'hA002, 14'd10000, 2'd1, 8'd2);
    enq(16'hA003, 14'h3FFF, 2'd2, 8'd3);
    enq(16'hA004, 14'd5000, 2'd3, 8'd4);

    // zero budget: zero-byte words stay, priority ties go to the tail
    set_config(blpq_pkg::MODE_HIGHEST_PRIO, 20'd0);
    enq(16'hB001, 14'd0, blpq_pkg::KIND_NORMAL, 8'd5);
    enq(16'hB002, 14'd1, blpq_pkg::KIND_NORMAL, 8'd5);
    enq(16'hB003, 14'd1, 2'd1, 8'd9);
    enq(16'hB004, 14'd0, 2'd1, 8'hFF);
    deq();
    deq();
    deq();
    deq();

    for (int p = 0; p < NumPhases; p++) begin
      limit = phase_limit[p];
      if (p == 6) limit = 20'($urandom);
      set_config(phase_mode[p], limit);
      no_gaps = (p == 4);
      for (int k = 0; k < phase_len[p]; k++) begin
        if ($urandom_range(99) < phase_enq[p]) begin
          send_word(blpq_pkg::OP_ENQUEUE, random_desc(phase_ties[p]));
        end else begin
          deq();
        end
      end
    end
    no_gaps = 1'b0;

    wait_quiet();
    $display("covered %0d enqueues with %0d evictions, %0d dequeues and %0d empty dequeues",
             mirror.n_enq, mirror.n_evict, mirror.n_deq, mirror.n_empty);
    $display("over %0d drop mode and byte limit settings plus the reset setting", n_settings);
    if (mirror.errors == 0 && mirror.replies_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/blpq_pkg.sv
rtl/blpq_ram.sv
rtl/blpq_ctrl.sv
rtl/byte_limited_packet_queue.sv
tb/testbench.sv
